### design/lkt_pkg.sv
// Shared types and constants for the LRU key tracker.
package lkt_pkg;

	localparam int KEY_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Opcodes of an input item
	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_DUMP   = 1'b1;

	typedef struct packed {
		logic                    opcode;
		logic signed [KEY_W-1:0] key;
	} lkt_in_t;

	typedef struct packed {
		logic                    hit;
		logic                    evicted;
		logic signed [KEY_W-1:0] evicted_key;
		logic                    listed_valid;
		logic signed [KEY_W-1:0] listed_key;
		logic                    last;
	} lkt_out_t;

	// Per-cell controls for one cycle
	typedef struct packed {
		logic shift; // take key/valid from the left neighbor
		logic pull;  // take key from the right neighbor (dump rotation)
		logic wrap;  // take the head key (dump rotation, tail cell)
		logic tail;  // this cell holds the least recent key
	} lkt_cell_ctl_t;

endpackage

### design/lkt_cell.sv
// One slot of the recency chain: a stored key, its valid bit and a key comparator.
module lkt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkt_pkg::lkt_cell_ctl_t        ctl,
	input  logic signed [lkt_pkg::KEY_W-1:0] cmp_key,
	input  logic signed [lkt_pkg::KEY_W-1:0] left_key,
	input  logic                          left_valid,
	input  logic signed [lkt_pkg::KEY_W-1:0] right_key,
	input  logic signed [lkt_pkg::KEY_W-1:0] head_key,
	output logic signed [lkt_pkg::KEY_W-1:0] key,
	output logic                          valid,
	output logic                          match,
	output logic signed [lkt_pkg::KEY_W-1:0] tap
);
	import lkt_pkg::*;

	logic signed [KEY_W-1:0] key_q;
	logic                    valid_q;

	// Key storage: shift toward the back on update, rotate toward the front on dump
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			key_q <= left_key;
		end else if (ctl.wrap) begin
			key_q <= head_key;
		end else if (ctl.pull) begin
			key_q <= right_key;
		end
	end

	// Valid follows the shift only; rotation stays within the valid slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= left_valid;
		end
	end

	assign key   = key_q;
	assign valid = valid_q;
	assign match = valid_q && (key_q == cmp_key);
	assign tap   = ctl.tail ? key_q : '0;

endmodule

### design/lru_key_tracker.sv
// Top level of the LRU key tracker: control, result register and the chain of key cells.
// Access: accept, compare cycle, update cycle; the next item is taken in the update cycle
//   when the result slot is free, so accesses overlap, paced by the compare register before the shift.
// Dump: count results (one if empty) after the accept cycle, one key per cycle while the result
//   slot is free, as the chain rotates through the head cell.
// Reset clears all valid bits, the key count and the state, and sets capacity to 16;
//   stored keys are not cleared.
module lru_key_tracker #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [lkt_pkg::CAP_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  lkt_pkg::lkt_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output lkt_pkg::lkt_out_t          out_data
);
	import lkt_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD,
		S_DUMP
	} state_t;

	state_t                  state_q;
	lkt_in_t                 req_q;
	lkt_out_t                out_q;
	logic                    out_valid_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	logic [CAP_W-1:0]        cap_q;
	logic [MAX_ENTRIES-1:0]  match_s1;
	logic                    full_s1;

	logic signed [KEY_W-1:0] cell_key   [MAX_ENTRIES];
	logic                    cell_valid [MAX_ENTRIES];
	logic signed [KEY_W-1:0] cell_tap   [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]  match_vec;
	lkt_cell_ctl_t           cell_ctl   [MAX_ENTRIES];

	logic                    slot_free;
	logic                    accept;
	logic                    upd_go;
	logic                    dump_go;
	logic                    out_load;
	logic                    hit_any;
	logic [CW-1:0]           hit_pos;
	logic [CW-1:0]           limit;
	logic [CW-1:0]           tail;
	logic [CW-1:0]           eff_cap;
	logic signed [KEY_W-1:0] victim;

	// Handshake
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) || ((state_q == S_UPD) && slot_free);
	assign accept    = in_valid && in_ready;
	assign upd_go    = (state_q == S_UPD) && slot_free;
	assign dump_go   = (state_q == S_DUMP) && slot_free && (count_q != '0);
	assign out_load  = upd_go || ((state_q == S_DUMP) && slot_free);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Effective capacity: zero reads as one, clamp to the number of cells
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (32'(cap_q) > 32'(MAX_ENTRIES)) begin
			eff_cap = CW'(MAX_ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	// Hit position (at most one cell matches) and victim key
	always_comb begin
		hit_pos = '0;
		victim  = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			if (match_s1[i]) begin
				hit_pos = hit_pos | CW'(i);
			end
			victim = victim | cell_tap[i];
		end
	end

	assign hit_any = |match_s1;
	assign tail    = count_q - CW'(1);
	assign limit   = hit_any ? hit_pos : (full_s1 ? tail : count_q);

	// Cell chain
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		always_comb begin
			cell_ctl[i].shift = upd_go && (CW'(i) <= limit);
			cell_ctl[i].pull  = dump_go && (CW'(i) < tail);
			cell_ctl[i].wrap  = dump_go && (CW'(i) == tail);
			cell_ctl[i].tail  = (CW'(i) == tail);
		end

		if (i == 0) begin : g_head
			lkt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (cell_ctl[i]),
				.cmp_key    (req_q.key),
				.left_key   (req_q.key),
				.left_valid (1'b1),
				.right_key  (cell_key[(i + 1) % MAX_ENTRIES]),
				.head_key   (cell_key[0]),
				.key        (cell_key[i]),
				.valid      (cell_valid[i]),
				.match      (match_vec[i]),
				.tap        (cell_tap[i])
			);
		end else if (i == MAX_ENTRIES - 1) begin : g_end
			lkt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (cell_ctl[i]),
				.cmp_key    (req_q.key),
				.left_key   (cell_key[i - 1]),
				.left_valid (cell_valid[i - 1]),
				.right_key  (cell_key[i]),
				.head_key   (cell_key[0]),
				.key        (cell_key[i]),
				.valid      (cell_valid[i]),
				.match      (match_vec[i]),
				.tap        (cell_tap[i])
			);
		end else begin : g_mid
			lkt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (cell_ctl[i]),
				.cmp_key    (req_q.key),
				.left_key   (cell_key[i - 1]),
				.left_valid (cell_valid[i - 1]),
				.right_key  (cell_key[i + 1]),
				.head_key   (cell_key[0]),
				.key        (cell_key[i]),
				.valid      (cell_valid[i]),
				.match      (match_vec[i]),
				.tap        (cell_tap[i])
			);
		end
	end

	// Request payload and compare results
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= in_data;
		end
		if (state_q == S_CMP) begin
			match_s1 <= match_vec;
			full_s1  <= (count_q >= eff_cap);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (upd_go) begin
			out_q.hit          <= hit_any;
			out_q.evicted      <= !hit_any && full_s1;
			out_q.evicted_key  <= (!hit_any && full_s1) ? victim : '0;
			out_q.listed_valid <= 1'b0;
			out_q.listed_key   <= '0;
			out_q.last         <= 1'b1;
		end else if (out_load) begin
			out_q.hit          <= 1'b0;
			out_q.evicted      <= 1'b0;
			out_q.evicted_key  <= '0;
			out_q.listed_valid <= (count_q != '0);
			out_q.listed_key   <= (count_q != '0) ? cell_key[0] : '0;
			out_q.last         <= (count_q == '0) || (idx_q == tail);
		end
	end

	// Control state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			idx_q       <= '0;
			cap_q       <= CAP_RESET;
		end else begin
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						state_q <= (in_data.opcode == OP_DUMP) ? S_DUMP : S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (upd_go) begin
						if (!hit_any && !full_s1) begin
							count_q <= count_q + CW'(1);
						end
						if (accept) begin
							idx_q   <= '0;
							state_q <= (in_data.opcode == OP_DUMP) ? S_DUMP : S_CMP;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DUMP: begin
					if (slot_free) begin
						if ((count_q == '0) || (idx_q == tail)) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### tb/sv/tb_lru_key_tracker.sv
// Self-checking testbench for the LRU key tracker: directed and random traffic with a scoreboard.
module tb_lru_key_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import lkt_pkg::*;

	localparam int DEPTH = 16;

	// Recency-order predictor plus queue of expected results
	class lru_scoreboard;
		logic signed [KEY_W-1:0] keys[DEPTH];
		int unsigned             count;
		logic [CAP_W-1:0]        capacity;
		lkt_out_t                expected_q[$];
		int unsigned             errors;

		function new();
			count = 0;
			capacity = CAP_RESET;
			errors = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] value);
			capacity = value;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function int unsigned total_errors();
			return errors + expected_q.size();
		endfunction

		function string show(lkt_out_t r);
			return $sformatf({"hit %0b evicted %0b evicted_key %h ",
				"listed_valid %0b listed_key %h last %0b"},
				r.hit, r.evicted, r.evicted_key, r.listed_valid, r.listed_key, r.last);
		endfunction

		// Work out the results of one accepted item and advance the key order
		function void note_input(lkt_in_t item);
			lkt_out_t    r;
			int          pos;
			int unsigned lim;
			int unsigned upto;
			r = '0;
			r.last = 1'b1;
			if (item.opcode == OP_DUMP) begin
				if (count == 0) begin
					expected_q.push_back(r);
				end else begin
					for (int i = 0; i < count; i++) begin
						r.listed_valid = 1'b1;
						r.listed_key = keys[i];
						r.last = (i == count - 1);
						expected_q.push_back(r);
					end
				end
				return;
			end
			// capacity zero acts as one, anything above the depth as the depth
			lim = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : capacity);
			pos = -1;
			for (int i = 0; i < count; i++) begin
				if (keys[i] == item.key) begin
					pos = i;
					break;
				end
			end
			if (pos >= 0) begin
				r.hit = 1'b1;
				upto = pos;
			end else if (count >= lim) begin
				// full, or capacity lowered below count: drop only the oldest key
				r.evicted = 1'b1;
				r.evicted_key = keys[count - 1];
				upto = count - 1;
			end else begin
				upto = count;
				count++;
			end
			for (int i = upto; i > 0; i--)
				keys[i] = keys[i - 1];
			keys[0] = item.key;
			expected_q.push_back(r);
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(lkt_out_t got);
			lkt_out_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR %0t: result with nothing expected: %s",
						$realtime, show(got));
				return;
			end
			want = expected_q.pop_front();
			if (got.hit !== want.hit || got.evicted !== want.evicted ||
					got.evicted_key !== want.evicted_key ||
					got.listed_valid !== want.listed_valid ||
					got.listed_key !== want.listed_key || got.last !== want.last) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR %0t: result differs", $realtime);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wen = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = CAP_RESET;
	logic             in_valid = 1'b0;
	logic             in_ready;
	lkt_in_t          in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	lkt_out_t         out_data;

	lru_scoreboard sb = new();
	bit            idle_on = 1'b0;
	int            ready_hold = 0;

	lru_key_tracker #(
		.MAX_ENTRIES(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// Watchdog
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Result-side backpressure in random bursts while idling is on; otherwise always ready
	always @(negedge clk) begin
		if (!idle_on) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (out_ready && $urandom_range(0, 99) < 25) begin
			out_ready <= 1'b0;
			ready_hold <= $urandom_range(0, 5);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Both transfers noted at the same edge, input first
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_input(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	function automatic lkt_in_t mk(logic op, logic [KEY_W-1:0] k);
		lkt_in_t item;
		item.opcode = op;
		item.key = k;
		return item;
	endfunction

	// Present one item, with an optional gap first, and hold it until the transfer
	task automatic send_item(lkt_in_t item);
		if (idle_on && $urandom_range(0, 99) < 25) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stop sending and wait until every expected result has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		settle();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		sb.set_capacity(value);
	endtask

	initial begin
		logic [KEY_W-1:0] pool[20];
		logic [CAP_W-1:0] cap_plan[8];
		int               pool_n;
		logic [KEY_W-1:0] k;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty dump, extreme keys, hits, eviction, odd capacities
		send_item(mk(OP_DUMP, 32'h0000_0000));
		send_item(mk(OP_ACCESS, 32'h8000_0000));
		send_item(mk(OP_ACCESS, 32'h7FFF_FFFF));
		send_item(mk(OP_ACCESS, 32'h0000_0000));
		send_item(mk(OP_ACCESS, 32'hFFFF_FFFF));
		send_item(mk(OP_ACCESS, 32'h8000_0000));
		send_item(mk(OP_ACCESS, 32'hFFFF_FFFF));
		send_item(mk(OP_DUMP, 32'hFFFF_FFFF));
		// capacity below the count: each miss drops one key, count stays
		write_capacity(5'd3);
		send_item(mk(OP_ACCESS, 32'h1234_5678));
		send_item(mk(OP_DUMP, 32'h0000_0000));
		// capacity zero behaves as one
		write_capacity(5'd0);
		send_item(mk(OP_ACCESS, 32'h0000_0005));
		send_item(mk(OP_ACCESS, 32'h0000_0005));
		send_item(mk(OP_DUMP, 32'h0000_0000));

		// Random phases; the last one and one in the middle run without idling
		cap_plan = '{5'd31, 5'd2, 5'd16, 5'd1, 5'd7, 5'd17, 5'd0, 5'd0};
		cap_plan[6] = CAP_W'($urandom_range(0, 31));
		cap_plan[7] = CAP_W'($urandom_range(0, 31));
		for (int ph = 0; ph < 8; ph++) begin
			write_capacity(cap_plan[ph]);
			idle_on = (ph != 3) && (ph != 7);
			pool_n = (ph == 0) ? 20 : $urandom_range(3, 20);
			for (int j = 0; j < 20; j++)
				pool[j] = $urandom();
			for (int n = 0; n < 26; n++) begin
				if ($urandom_range(0, 99) < 12) begin
					send_item(mk(OP_DUMP, $urandom()));
				end else begin
					k = ($urandom_range(0, 99) < 80) ?
						pool[$urandom_range(0, pool_n - 1)] : $urandom();
					send_item(mk(OP_ACCESS, k));
				end
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (sb.total_errors() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
